### src/ucer_pkg.sv
// ----------------------------------------------------------------------------
// ucer_pkg: shared types and codes of the endpoint-zero responder
// Event and request codes, descriptor types, IN sources, register indexes and
// the command and result records passed between the front, queues and back.
// ----------------------------------------------------------------------------
`default_nettype none

package ucer_pkg;

  // event codes
  localparam logic [1:0] OP_SETUP     = 2'd0;
  localparam logic [1:0] OP_OUT       = 2'd1;
  localparam logic [1:0] OP_IN        = 2'd2;
  localparam logic [1:0] OP_BUS_RESET = 2'd3;

  // standard requests
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;

  // class requests
  localparam logic [7:0] CLS_GET_REPORT = 8'd1;
  localparam logic [7:0] CLS_SET_REPORT = 8'd9;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_HID    = 8'h21;

  // IN data sources
  localparam logic [2:0] SRC_ZEROS     = 3'd0;
  localparam logic [2:0] SRC_DEVICE    = 3'd1;
  localparam logic [2:0] SRC_CONFIG    = 3'd2;
  localparam logic [2:0] SRC_HID       = 3'd3;
  localparam logic [2:0] SRC_STRING    = 3'd4;
  localparam logic [2:0] SRC_CFG_VALUE = 3'd5;
  localparam logic [2:0] SRC_SCRATCH   = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_DESC_LEN = 3'd0;
  localparam logic [2:0] REG_CONFIG_DESC_LEN = 3'd1;
  localparam logic [2:0] REG_HID_DESC_LEN    = 3'd2;
  localparam logic [2:0] REG_STRING0_LEN     = 3'd3;
  localparam logic [2:0] REG_STRING1_LEN     = 3'd4;
  localparam logic [2:0] REG_STRING2_LEN     = 3'd5;
  localparam logic [2:0] REG_STRING3_LEN     = 3'd6;

  localparam logic [15:0] STATUS_MARK = 16'hFFFF;
  localparam logic [31:0] RUN_MAGIC   = 32'h1234abcd;
  localparam logic [7:0]  ADDR_ENABLE = 8'h80;

  typedef enum logic [2:0] {
    ACT_SEND,
    ACT_STATUS,
    ACT_SET_ADDR,
    ACT_SET_CFG,
    ACT_RECV,
    ACT_OUT,
    ACT_IN,
    ACT_BUS_RESET
  } act_e;

  // classified event; len carries send length, upload length or OUT length
  typedef struct packed {
    act_e        act;
    logic [2:0]  src;
    logic [1:0]  idx;
    logic [15:0] len;
    logic [7:0]  arg;
    logic        magic;
  } cmd_t;

  typedef struct packed {
    logic        tx_arm;
    logic [2:0]  tx_source;
    logic [1:0]  tx_string_index;
    logic [12:0] tx_offset;
    logic [6:0]  tx_len;
    logic        rx_arm;
    logic [12:0] write_offset;
    logic        address_write;
    logic [7:0]  device_address;
    logic        function_enable;
    logic        run_request;
    logic [7:0]  current_config;
  } res_t;

endpackage

`default_nettype wire

### src/usb_control_endpoint_responder_core.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder_core: endpoint-zero control responder
// Classifies endpoint-zero events, queues them and runs the control transfer
// state, producing one result record per event.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  event    | in        | push / full                | opcode .. tail_word
//  result   | out       | empty / pop                | tx_arm .. current_config
//  config   | in        | cfg_we_i, cfg_idx_i        | cfg_wdata_i (10 bits)
//
//  One event per cycle sustained while results are popped; with nothing
//  queued ahead, an event passes the event queue, then the result queue.
//  The rate is set by the back end's state update loop.
//  Reset clears the transfer state and loads the default descriptor lengths.
//  A stalled result side fills the result queue, then the event queue, then
//  raises full; each queue holds two entries.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_endpoint_responder_core #(
  parameter int SCRATCH_BYTES = 6272,
  parameter int PACKET_BYTES  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  req_type_i,
  input  wire logic [7:0]  request_i,
  input  wire logic [15:0] setup_value_i,
  input  wire logic [15:0] setup_length_i,
  input  wire logic [6:0]  out_len_i,
  input  wire logic [31:0] tail_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             tx_arm_o,
  output logic [2:0]       tx_source_o,
  output logic [1:0]       tx_string_index_o,
  output logic [12:0]      tx_offset_o,
  output logic [6:0]       tx_len_o,
  output logic             rx_arm_o,
  output logic [12:0]      write_offset_o,
  output logic             address_write_o,
  output logic [7:0]       device_address_o,
  output logic             function_enable_o,
  output logic             run_request_o,
  output logic [7:0]       current_config_o
);

  import ucer_pkg::*;

  localparam int CmdW = $bits(cmd_t);
  localparam int ResW = $bits(res_t);

  cmd_t            cmd_in, cmd_head;
  res_t            res_new, res_head;
  logic [CmdW-1:0] cmd_head_raw;
  logic [ResW-1:0] res_head_raw;
  logic            cmd_empty, cmd_pop, res_full, res_push;

  ucer_front #(
    .ScratchBytes(SCRATCH_BYTES),
    .PacketBytes (PACKET_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .opcode_i,
    .req_type_i,
    .request_i,
    .setup_value_i,
    .setup_length_i,
    .out_len_i,
    .tail_word_i,
    .cmd_o(cmd_in)
  );

  ucer_fifo #(
    .Width(CmdW),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_head_raw),
    .empty_o(cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_raw);

  ucer_back #(
    .PacketBytes(PACKET_BYTES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(~cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_new)
  );

  ucer_fifo #(
    .Width(ResW),
    .Depth(2)
  ) u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_i (res_push),
    .wdata_i(res_new),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_head_raw),
    .empty_o(empty)
  );

  assign res_head          = res_t'(res_head_raw);
  assign tx_arm_o          = res_head.tx_arm;
  assign tx_source_o       = res_head.tx_source;
  assign tx_string_index_o = res_head.tx_string_index;
  assign tx_offset_o       = res_head.tx_offset;
  assign tx_len_o          = res_head.tx_len;
  assign rx_arm_o          = res_head.rx_arm;
  assign write_offset_o    = res_head.write_offset;
  assign address_write_o   = res_head.address_write;
  assign device_address_o  = res_head.device_address;
  assign function_enable_o = res_head.function_enable;
  assign run_request_o     = res_head.run_request;
  assign current_config_o  = res_head.current_config;

`ifndef SYNTHESIS
  a_bus_reset_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd_head.act == ACT_BUS_RESET) |->
      (res_new.function_enable && res_new.rx_arm && !res_new.tx_arm))
    else $error("bus reset result malformed");

  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_new.tx_len <= 7'(PACKET_BYTES)))
    else $error("IN chunk longer than a packet");

  a_addr_on_in_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_new.address_write) |-> (cmd_head.act == ACT_IN))
    else $error("address written outside an IN completion");

  a_event_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && cmd_empty) |=> !cmd_empty)
    else $error("accepted event lost before the back end");
`endif

endmodule

`default_nettype wire

### src/ucer_fifo.sv
// ----------------------------------------------------------------------------
// ucer_fifo: small synchronous queue
// Register-based FIFO; push and pop may both happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ucer_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### src/ucer_front.sv
// ----------------------------------------------------------------------------
// ucer_front: event classifier and descriptor length registers
// Decodes each event into a command and clips send, upload and OUT lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module ucer_front #(
  parameter int ScratchBytes = 6272,
  parameter int PacketBytes  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  req_type_i,
  input  wire logic [7:0]  request_i,
  input  wire logic [15:0] setup_value_i,
  input  wire logic [15:0] setup_length_i,
  input  wire logic [6:0]  out_len_i,
  input  wire logic [31:0] tail_word_i,
  output ucer_pkg::cmd_t   cmd_o
);

  import ucer_pkg::*;

  localparam logic [15:0] ScratchLen = 16'(ScratchBytes);
  localparam logic [6:0]  PacketLen  = 7'(PacketBytes);

  logic [7:0]  dev_len_q, hid_len_q;
  logic [9:0]  cfg_len_q;
  logic [7:0]  str_len_q [4];
  logic [15:0] lim, clipped;
  logic        std_req, str_ok;
  logic [7:0]  desc_type;

  assign std_req   = (req_type_i[6:5] == 2'b00);
  assign desc_type = setup_value_i[15:8];
  assign str_ok    = (setup_value_i[7:2] == 6'd0);

  // upper bound for the host's wLength
  always_comb begin
    lim = ScratchLen;
    if (std_req) begin
      case (desc_type)
        DESC_DEVICE: lim = {8'd0, dev_len_q};
        DESC_CONFIG: lim = {6'd0, cfg_len_q};
        DESC_HID:    lim = {8'd0, hid_len_q};
        DESC_STRING: lim = {8'd0, str_len_q[setup_value_i[1:0]]};
        default:     lim = '0;
      endcase
    end
  end

  assign clipped = (setup_length_i < lim) ? setup_length_i : lim;

  always_comb begin
    cmd_o     = '0;
    cmd_o.act = ACT_STATUS;
    case (opcode_i)
      OP_SETUP: begin
        if (std_req) begin
          case (request_i)
            REQ_GET_STATUS: begin
              cmd_o.act = ACT_SEND;
              cmd_o.src = SRC_ZEROS;
              cmd_o.len = 16'd2;
            end
            REQ_SET_ADDRESS: begin
              cmd_o.act = ACT_SET_ADDR;
              cmd_o.arg = setup_value_i[7:0];
            end
            REQ_GET_DESCRIPTOR: begin
              cmd_o.act = ACT_SEND;
              cmd_o.len = clipped;
              case (desc_type)
                DESC_DEVICE: cmd_o.src = SRC_DEVICE;
                DESC_CONFIG: cmd_o.src = SRC_CONFIG;
                DESC_HID:    cmd_o.src = SRC_HID;
                DESC_STRING: begin
                  if (str_ok) begin
                    cmd_o.src = SRC_STRING;
                    cmd_o.idx = setup_value_i[1:0];
                  end else begin
                    cmd_o.src = SRC_ZEROS;
                    cmd_o.len = '0;
                  end
                end
                default: begin
                  cmd_o.src = SRC_ZEROS;
                  cmd_o.len = '0;
                end
              endcase
            end
            REQ_GET_CONFIG: begin
              cmd_o.act = ACT_SEND;
              cmd_o.src = SRC_CFG_VALUE;
              cmd_o.len = 16'd1;
            end
            REQ_SET_CONFIG: begin
              cmd_o.act = ACT_SET_CFG;
              cmd_o.arg = setup_value_i[7:0];
            end
            REQ_GET_INTERFACE: begin
              cmd_o.act = ACT_SEND;
              cmd_o.src = SRC_ZEROS;
              cmd_o.len = 16'd1;
            end
            default: cmd_o.act = ACT_STATUS;
          endcase
        end else begin
          case (request_i)
            CLS_SET_REPORT: begin
              cmd_o.act = ACT_RECV;
              cmd_o.len = clipped;
            end
            CLS_GET_REPORT: begin
              cmd_o.act = ACT_SEND;
              cmd_o.src = SRC_SCRATCH;
              cmd_o.len = clipped;
            end
            default: cmd_o.act = ACT_STATUS;
          endcase
        end
      end
      OP_OUT: begin
        cmd_o.act   = ACT_OUT;
        cmd_o.len   = {9'd0, (out_len_i > PacketLen) ? PacketLen : out_len_i};
        cmd_o.magic = (tail_word_i == RUN_MAGIC);
      end
      OP_IN:        cmd_o.act = ACT_IN;
      OP_BUS_RESET: cmd_o.act = ACT_BUS_RESET;
      default:      cmd_o.act = ACT_STATUS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_len_q    <= 8'd18;
      cfg_len_q    <= 10'd34;
      hid_len_q    <= 8'd9;
      str_len_q[0] <= 8'd4;
      str_len_q[1] <= 8'd0;
      str_len_q[2] <= 8'd0;
      str_len_q[3] <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEVICE_DESC_LEN: dev_len_q    <= cfg_wdata_i[7:0];
        REG_CONFIG_DESC_LEN: cfg_len_q    <= cfg_wdata_i;
        REG_HID_DESC_LEN:    hid_len_q    <= cfg_wdata_i[7:0];
        REG_STRING0_LEN:     str_len_q[0] <= cfg_wdata_i[7:0];
        REG_STRING1_LEN:     str_len_q[1] <= cfg_wdata_i[7:0];
        REG_STRING2_LEN:     str_len_q[2] <= cfg_wdata_i[7:0];
        REG_STRING3_LEN:     str_len_q[3] <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/ucer_back.sv
// ----------------------------------------------------------------------------
// ucer_back: control transfer engine
// Holds the send, receive, address and configuration state, applies one
// command per cycle while the result queue has room and builds the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module ucer_back #(
  parameter int PacketBytes = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire ucer_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output ucer_pkg::res_t      res_o
);

  import ucer_pkg::*;

  localparam logic [6:0] PacketLen = 7'(PacketBytes);

  logic [2:0]  src_q, src_d, src_m;
  logic [1:0]  idx_q, idx_d, idx_m;
  logic [12:0] off_q, off_d, off_m;
  logic [15:0] pend_q, pend_d, pend_m;
  logic [12:0] rp_q, rp_d, ro_q, ro_d;
  logic [7:0]  paddr_q, paddr_d, cfgv_q, cfgv_d;
  logic [12:0] out_len;
  logic [6:0]  chunk;

  assign cmd_pop_o  = cmd_valid_i & ~res_full_i;
  assign res_push_o = cmd_pop_o;
  assign out_len    = cmd_i.len[12:0];

  always_comb begin
    res_o   = '0;
    src_m   = src_q;
    idx_m   = idx_q;
    off_m   = off_q;
    pend_m  = pend_q;
    rp_d    = rp_q;
    ro_d    = ro_q;
    paddr_d = paddr_q;
    cfgv_d  = cfgv_q;
    chunk   = '0;

    // setup and OUT effects
    case (cmd_i.act)
      ACT_SEND: begin
        src_m  = cmd_i.src;
        idx_m  = cmd_i.idx;
        off_m  = '0;
        pend_m = cmd_i.len;
      end
      ACT_STATUS: pend_m = STATUS_MARK;
      ACT_SET_ADDR: begin
        pend_m  = STATUS_MARK;
        paddr_d = cmd_i.arg;
      end
      ACT_SET_CFG: begin
        pend_m = STATUS_MARK;
        cfgv_d = cmd_i.arg;
      end
      ACT_RECV: begin
        rp_d         = cmd_i.len[12:0];
        ro_d         = '0;
        res_o.rx_arm = 1'b1;
      end
      ACT_OUT: begin
        if (out_len != '0) begin
          if (rp_q != '0) begin
            res_o.write_offset = ro_q;
            ro_d = ro_q + out_len;
            rp_d = (rp_q > out_len) ? rp_q - out_len : '0;
            res_o.run_request = (rp_q <= out_len) && cmd_i.magic;
          end
          pend_m = STATUS_MARK;
        end
        res_o.rx_arm = 1'b1;
      end
      default: ;
    endcase

    src_d  = src_m;
    idx_d  = idx_m;
    off_d  = off_m;
    pend_d = pend_m;

    if (cmd_i.act == ACT_BUS_RESET) begin
      res_o.rx_arm          = 1'b1;
      res_o.function_enable = 1'b1;
    end else if (pend_m == '0) begin
      src_d        = SRC_ZEROS;
      idx_d        = '0;
      off_d        = '0;
      res_o.rx_arm = 1'b1;
    end else if (pend_m == STATUS_MARK) begin
      res_o.tx_arm = 1'b1;
      pend_d       = '0;
    end else begin
      chunk                 = (pend_m < {9'd0, PacketLen}) ? pend_m[6:0] : PacketLen;
      res_o.tx_arm          = 1'b1;
      res_o.tx_source       = src_m;
      res_o.tx_string_index = (src_m == SRC_STRING) ? idx_m : 2'd0;
      res_o.tx_offset       = off_m;
      res_o.tx_len          = chunk;
      off_d                 = off_m + {6'd0, chunk};
      pend_d                = pend_m - {9'd0, chunk};
    end

    // address takes effect once the status IN has gone out
    if (cmd_i.act == ACT_IN && paddr_q != '0) begin
      res_o.address_write  = 1'b1;
      res_o.device_address = ADDR_ENABLE | paddr_q;
      paddr_d              = '0;
    end

    res_o.current_config = cfgv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= '0;
      idx_q   <= '0;
      off_q   <= '0;
      pend_q  <= '0;
      rp_q    <= '0;
      ro_q    <= '0;
      paddr_q <= '0;
      cfgv_q  <= '0;
    end else if (cmd_pop_o) begin
      src_q   <= src_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      pend_q  <= pend_d;
      rp_q    <= rp_d;
      ro_q    <= ro_d;
      paddr_q <= paddr_d;
      cfgv_q  <= cfgv_d;
    end
  end

endmodule

`default_nettype wire
